// ===== sv/ros_pkg.sv =====
// Shared types, widths, codes and helper functions of the rectangle overlap tester.
`default_nettype none
package ros_pkg;

  // Coordinate and derived arithmetic widths
  localparam int COORD_WIDTH = 16;
  localparam int EDGE_WIDTH  = COORD_WIDTH + 1;
  localparam int PROD_WIDTH  = COORD_WIDTH + EDGE_WIDTH;
  localparam int PROJ_WIDTH  = PROD_WIDTH + 1;

  // One axis cell per separating axis candidate
  localparam int NUM_CELLS   = 4;
  localparam int NUM_CORNERS = 4;

  // Stream widths
  localparam int IN_DATA_WIDTH  = 2 * NUM_CORNERS * COORD_WIDTH;
  localparam int OUT_DATA_WIDTH = 8;

  // Command codes carried in tuser
  localparam logic CMD_LOAD = 1'b0;
  localparam logic CMD_TEST = 1'b1;

  typedef struct packed {
    logic signed [COORD_WIDTH-1:0] x;
    logic signed [COORD_WIDTH-1:0] y;
  } point_t;

  typedef point_t [NUM_CORNERS-1:0] rect_t;

  typedef struct packed {
    logic signed [EDGE_WIDTH-1:0] ex;
    logic signed [EDGE_WIDTH-1:0] ey;
  } axis_t;

  // Work item that travels along the cell chain
  typedef struct packed {
    rect_t                     ra;
    rect_t                     rb;
    axis_t [NUM_CELLS-1:0]     axes;
    logic                      ok;
  } item_t;

  // Edge vector p - q, exact at one bit more than a coordinate
  function automatic axis_t edge_of(point_t p, point_t q);
    axis_t e;
    e.ex = EDGE_WIDTH'($signed(p.x)) - EDGE_WIDTH'($signed(q.x));
    e.ey = EDGE_WIDTH'($signed(p.y)) - EDGE_WIDTH'($signed(q.y));
    return e;
  endfunction

  // Exact signed coordinate by edge component product
  function automatic logic signed [PROD_WIDTH-1:0] mul(
    logic signed [COORD_WIDTH-1:0] a,
    logic signed [EDGE_WIDTH-1:0]  b
  );
    logic signed [PROD_WIDTH-1:0] aw;
    logic signed [PROD_WIDTH-1:0] bw;
    aw = PROD_WIDTH'(a);
    bw = PROD_WIDTH'(b);
    return aw * bw;
  endfunction

endpackage
`default_nettype wire

// ===== sv/rect_overlap_sat.sv =====
// Top level of the separating axis rectangle overlap tester.
//
// Input stream (s_*): one beat carries four corners of a rectangle in tdata
// and a command in tuser. A load beat stores the corners as the reference
// rectangle and yields no result. A test beat checks the beat's rectangle
// against the reference as it stands when the beat is taken, and yields one
// result beat on m_* whose bit 0 is 1 when the rectangles overlap or touch.
// Results leave in the order of the test beats.
// Throughput: one beat per cycle while the receiver keeps up. A test beat passes
// through one front stage that forms the edge vectors, then four axis cells of three
// stages each (products, projections with pairwise min/max, range compare).
// Every stage holds a valid bit and is loaded when it is empty or its
// successor moves, so a stalled receiver only blocks once the chain is full
// and empty slots keep taking input meanwhile.
// Reset clears every valid bit and sets the reference rectangle to four
// corners at the origin.
`default_nettype none
module rect_overlap_sat (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire logic                                s_tvalid,
  output logic                                     s_tready,
  // corner0_x, corner0_y, corner1_x, corner1_y, corner2_x, corner2_y,
  // corner3_x, corner3_y (16 bits each)
  input  wire logic [ros_pkg::IN_DATA_WIDTH-1:0]   s_tdata,
  // cmd
  input  wire logic                                s_tuser,
  output logic                                     m_tvalid,
  input  wire logic                                m_tready,
  // overlaps, then zero padding
  output logic [ros_pkg::OUT_DATA_WIDTH-1:0]       m_tdata
);

  localparam int CW = ros_pkg::COORD_WIDTH;

  ros_pkg::rect_t in_rect;
  logic           cv [ros_pkg::NUM_CELLS+1];
  logic           cr [ros_pkg::NUM_CELLS+1];
  ros_pkg::item_t ci [ros_pkg::NUM_CELLS+1];

  // Unpack the corners from the beat
  always_comb begin
    for (int k = 0; k < ros_pkg::NUM_CORNERS; k++) begin
      in_rect[k].x = s_tdata[2*CW*k +: CW];
      in_rect[k].y = s_tdata[2*CW*k + CW +: CW];
    end
  end

  ros_front u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_tvalid),
    .in_ready  (s_tready),
    .in_cmd    (s_tuser),
    .in_rect   (in_rect),
    .out_valid (cv[0]),
    .out_ready (cr[0]),
    .out_item  (ci[0])
  );

  // Chain of axis cells
  for (genvar g = 0; g < ros_pkg::NUM_CELLS; g++) begin : g_cell
    ros_cell u_cell (
      .clk       (clk),
      .rst       (rst),
      .in_valid  (cv[g]),
      .in_ready  (cr[g]),
      .in_item   (ci[g]),
      .out_valid (cv[g+1]),
      .out_ready (cr[g+1]),
      .out_item  (ci[g+1])
    );
  end

  // Drive the result beat from the last cell's register
  assign m_tvalid                 = cv[ros_pkg::NUM_CELLS];
  assign cr[ros_pkg::NUM_CELLS]   = m_tready;
  assign m_tdata = ros_pkg::OUT_DATA_WIDTH'(ci[ros_pkg::NUM_CELLS].ok);

endmodule
`default_nettype wire

// ===== sv/ros_front.sv =====
// Front stage: reference rectangle store and edge vector computation.
`default_nettype none
module ros_front (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           in_valid,
  output logic                in_ready,
  input  wire logic           in_cmd,
  input  wire ros_pkg::rect_t in_rect,
  output logic                out_valid,
  input  wire logic           out_ready,
  output ros_pkg::item_t      out_item
);

  ros_pkg::rect_t ref_rect;
  ros_pkg::item_t item_next;
  logic           accept;

  assign in_ready = !out_valid || out_ready;
  assign accept   = in_valid && in_ready;

  // Build the work item against the reference as it stands before this beat
  always_comb begin
    item_next         = '0;
    item_next.ra      = ref_rect;
    item_next.rb      = in_rect;
    item_next.axes[0] = ros_pkg::edge_of(ref_rect[1], ref_rect[0]);
    item_next.axes[1] = ros_pkg::edge_of(ref_rect[3], ref_rect[0]);
    item_next.axes[2] = ros_pkg::edge_of(in_rect[1], in_rect[0]);
    item_next.axes[3] = ros_pkg::edge_of(in_rect[3], in_rect[0]);
    item_next.ok      = 1'b1;
  end

  // Hold the reference and the stage valid; only test beats enter the chain
  always_ff @(posedge clk) begin
    if (rst) begin
      ref_rect  <= '0;
      out_valid <= 1'b0;
    end else begin
      if (in_ready) begin
        out_valid <= in_valid && (in_cmd == ros_pkg::CMD_TEST);
      end
      if (accept && (in_cmd == ros_pkg::CMD_LOAD)) begin
        ref_rect <= in_rect;
      end
    end
  end

  // Load the stage payload
  always_ff @(posedge clk) begin
    if (in_ready) begin
      out_item <= item_next;
    end
  end

endmodule
`default_nettype wire

// ===== sv/ros_cell.sv =====
// Axis cell: projects all eight corners on one axis and checks for separation.
`default_nettype none
module ros_cell (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           in_valid,
  output logic                in_ready,
  input  wire ros_pkg::item_t in_item,
  output logic                out_valid,
  input  wire logic           out_ready,
  output ros_pkg::item_t      out_item
);

  localparam int NPTS = 2 * ros_pkg::NUM_CORNERS;

  ros_pkg::point_t pts [NPTS];

  // Stage 1: products
  logic                                   v1;
  logic                                   rdy1;
  ros_pkg::item_t                         it1;
  logic signed [ros_pkg::PROD_WIDTH-1:0]  py [NPTS];
  logic signed [ros_pkg::PROD_WIDTH-1:0]  px [NPTS];

  // Stage 2: projections reduced pairwise
  logic                                   v2;
  logic                                   rdy2;
  ros_pkg::item_t                         it2;
  logic signed [ros_pkg::PROJ_WIDTH-1:0]  proj  [NPTS];
  logic signed [ros_pkg::PROJ_WIDTH-1:0]  lo_next [NPTS/2];
  logic signed [ros_pkg::PROJ_WIDTH-1:0]  hi_next [NPTS/2];
  logic signed [ros_pkg::PROJ_WIDTH-1:0]  lo2 [NPTS/2];
  logic signed [ros_pkg::PROJ_WIDTH-1:0]  hi2 [NPTS/2];

  // Stage 3: range compare and hand-off
  logic                                   rdy3;
  logic signed [ros_pkg::PROJ_WIDTH-1:0]  lo_a;
  logic signed [ros_pkg::PROJ_WIDTH-1:0]  hi_a;
  logic signed [ros_pkg::PROJ_WIDTH-1:0]  lo_b;
  logic signed [ros_pkg::PROJ_WIDTH-1:0]  hi_b;
  logic                                   sep;
  ros_pkg::item_t                         item_next;

  // Ready chain lets bubbles collapse
  assign rdy3     = !out_valid || out_ready;
  assign rdy2     = !v2 || rdy3;
  assign rdy1     = !v1 || rdy2;
  assign in_ready = rdy1;

  // Gather the reference corners then the incoming corners
  always_comb begin
    for (int k = 0; k < ros_pkg::NUM_CORNERS; k++) begin
      pts[k]                        = in_item.ra[k];
      pts[k + ros_pkg::NUM_CORNERS] = in_item.rb[k];
    end
  end

  // Advance the valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      v1        <= 1'b0;
      v2        <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (rdy1) begin
        v1 <= in_valid;
      end
      if (rdy2) begin
        v2 <= v1;
      end
      if (rdy3) begin
        out_valid <= v2;
      end
    end
  end

  // Multiply every corner by the normal of the current axis
  always_ff @(posedge clk) begin
    if (rdy1) begin
      it1 <= in_item;
      for (int k = 0; k < NPTS; k++) begin
        py[k] <= ros_pkg::mul(pts[k].y, in_item.axes[0].ex);
        px[k] <= ros_pkg::mul(pts[k].x, in_item.axes[0].ey);
      end
    end
  end

  // Form projections and the pairwise min and max
  always_comb begin
    for (int k = 0; k < NPTS; k++) begin
      proj[k] = ros_pkg::PROJ_WIDTH'(py[k]) - ros_pkg::PROJ_WIDTH'(px[k]);
    end
    for (int g = 0; g < NPTS / 2; g++) begin
      lo_next[g] = (proj[2*g] < proj[2*g+1]) ? proj[2*g] : proj[2*g+1];
      hi_next[g] = (proj[2*g] > proj[2*g+1]) ? proj[2*g] : proj[2*g+1];
    end
  end

  always_ff @(posedge clk) begin
    if (rdy2) begin
      it2 <= it1;
      for (int g = 0; g < NPTS / 2; g++) begin
        lo2[g] <= lo_next[g];
        hi2[g] <= hi_next[g];
      end
    end
  end

  // Finish the ranges, test for a gap, rotate the next axis into place
  always_comb begin
    lo_a = (lo2[0] < lo2[1]) ? lo2[0] : lo2[1];
    hi_a = (hi2[0] > hi2[1]) ? hi2[0] : hi2[1];
    lo_b = (lo2[2] < lo2[3]) ? lo2[2] : lo2[3];
    hi_b = (hi2[2] > hi2[3]) ? hi2[2] : hi2[3];
    sep  = (hi_a < lo_b) || (hi_b < lo_a);
    item_next    = it2;
    item_next.ok = it2.ok && !sep;
    for (int j = 0; j < ros_pkg::NUM_CELLS; j++) begin
      item_next.axes[j] = it2.axes[2'(j + 1)];
    end
  end

  always_ff @(posedge clk) begin
    if (rdy3) begin
      out_item <= item_next;
    end
  end

endmodule
`default_nettype wire

// ===== sv/ros_checker.sv =====
// Port-level checker for the rectangle overlap tester, bound to the top level.
`default_nettype none
module ros_checker (
  input wire logic                                clk,
  input wire logic                                rst,
  input wire logic                                s_tready,
  input wire logic                                m_tvalid,
  input wire logic                                m_tready,
  input wire logic [ros_pkg::OUT_DATA_WIDTH-1:0]  m_tdata
);

  // Reset empties the chain
  a_reset_empty: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("result beat present right after reset");

  // A stalled result beat holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("stalled result beat changed");

  // An open receiver keeps the whole chain moving
  a_flow: assert property (@(posedge clk) m_tready |-> s_tready)
    else $error("input stalled while receiver was ready");

  // Padding bits of a result beat stay zero
  a_pad: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tdata[ros_pkg::OUT_DATA_WIDTH-1:1] == '0))
    else $error("result padding not zero");

endmodule

bind rect_overlap_sat ros_checker u_ros_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);
`default_nettype wire

// ===== test/tb_rect_overlap_sat.sv =====
// Self-checking testbench for the separating axis rectangle overlap tester.
module tb_rect_overlap_sat;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int LATENCY    = 13;
  localparam int RAND_ITEMS = 1080;
  localparam int MAX_SHOWN  = 10;

  // Eight coordinates in stream order: corner0_x, corner0_y, ... corner3_y
  typedef logic signed [ros_pkg::COORD_WIDTH-1:0] coord_t;
  typedef coord_t [2*ros_pkg::NUM_CORNERS-1:0]    quad_t;

  logic                               clk      = 1'b0;
  logic                               rst      = 1'b1;
  logic                               s_tvalid = 1'b0;
  logic                               s_tready;
  // corner0_x, corner0_y, corner1_x, corner1_y, corner2_x, corner2_y,
  // corner3_x, corner3_y (16 bits each)
  logic [ros_pkg::IN_DATA_WIDTH-1:0]  s_tdata  = '0;
  // cmd
  logic                               s_tuser  = ros_pkg::CMD_LOAD;
  logic                               m_tvalid;
  logic                               m_tready = 1'b0;
  // overlaps, then zero padding
  logic [ros_pkg::OUT_DATA_WIDTH-1:0] m_tdata;

  // Expected overlap flags in test-beat order, and the mirrored reference
  bit    overlap_q[$];
  quad_t ref_quad   = '0;
  int    fail_count = 0;

  // Idling controls and the shape of the current reference rectangle
  bit    tx_free = 1'b0;
  bit    rx_free = 1'b0;
  int    rx_hold = 0;
  int    ref_cx, ref_cy, ref_ux, ref_uy, ref_t;
  bit    ref_shaped;

  rect_overlap_sat u_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Give up after a fixed time well beyond the slowest legal run
  initial begin
    #5_000_000;
    $display("** rect_overlap_sat: FAILED **");
    $finish;
  end

  // ---------------------------------------------------------------------
  // Overlap predictor
  // ---------------------------------------------------------------------

  // Range of the four corners of r projected on the normal of edge (ex, ey)
  function automatic void axis_span(input quad_t r, input longint ex, input longint ey,
                                    output longint lo, output longint hi);
    longint p;
    lo = 0;
    hi = 0;
    for (int k = 0; k < ros_pkg::NUM_CORNERS; k++) begin
      p = longint'($signed(r[2*k])) * (-ey) + longint'($signed(r[2*k+1])) * ex;
      if (k == 0 || p < lo) lo = p;
      if (k == 0 || p > hi) hi = p;
    end
  endfunction

  // No separating axis among the c1-c0 and c3-c0 normals of both rectangles
  function automatic bit rects_overlap(quad_t a, quad_t b);
    longint ex[4];
    longint ey[4];
    longint lo_a, hi_a, lo_b, hi_b;
    bit     hit;
    ex[0] = longint'($signed(a[2])) - longint'($signed(a[0]));
    ey[0] = longint'($signed(a[3])) - longint'($signed(a[1]));
    ex[1] = longint'($signed(a[6])) - longint'($signed(a[0]));
    ey[1] = longint'($signed(a[7])) - longint'($signed(a[1]));
    ex[2] = longint'($signed(b[2])) - longint'($signed(b[0]));
    ey[2] = longint'($signed(b[3])) - longint'($signed(b[1]));
    ex[3] = longint'($signed(b[6])) - longint'($signed(b[0]));
    ey[3] = longint'($signed(b[7])) - longint'($signed(b[1]));
    hit = 1'b1;
    for (int i = 0; i < 4; i++) begin
      axis_span(a, ex[i], ey[i], lo_a, hi_a);
      axis_span(b, ex[i], ey[i], lo_b, hi_b);
      if (hi_a < lo_b || hi_b < lo_a) hit = 1'b0;
    end
    return hit;
  endfunction

  // ---------------------------------------------------------------------
  // Monitor: check result beats, predict from accepted input beats
  // ---------------------------------------------------------------------

  task automatic note_fail(string msg);
    fail_count++;
    if (fail_count <= MAX_SHOWN) $display("%s", msg);
  endtask

  always @(posedge clk) begin
    logic [ros_pkg::OUT_DATA_WIDTH-1:0] want;
    if (!rst) begin
      // Result beats first: none can stem from the beat taken at this edge
      if (m_tvalid && m_tready) begin
        if (overlap_q.size() == 0) begin
          note_fail($sformatf("result beat %02h with no test pending", m_tdata));
        end else begin
          want = ros_pkg::OUT_DATA_WIDTH'(overlap_q.pop_front());
          if (m_tdata !== want)
            note_fail($sformatf("overlap mismatch: expected %02h, got %02h", want, m_tdata));
        end
      end
      if (s_tvalid && s_tready) begin
        if (s_tuser == ros_pkg::CMD_LOAD) ref_quad = s_tdata;
        else overlap_q.push_back(rects_overlap(ref_quad, s_tdata));
      end
    end
  end

  // ---------------------------------------------------------------------
  // Idling on both sides
  // ---------------------------------------------------------------------

  // Mostly short idle stretches, a few long ones
  function automatic int idle_len();
    if ($urandom_range(0, 9) < 8) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // Receiver: alternate ready runs and stalls unless told to stay ready
  always @(posedge clk) begin
    if (rx_free) begin
      m_tready <= 1'b1;
    end else if (rx_hold == 0) begin
      if (m_tready) begin
        m_tready <= 1'b0;
        rx_hold = idle_len() - 1;
      end else begin
        m_tready <= 1'b1;
        rx_hold = $urandom_range(0, 12);
      end
    end else begin
      rx_hold--;
    end
  end

  // ---------------------------------------------------------------------
  // Beat construction and sending
  // ---------------------------------------------------------------------

  function automatic quad_t corners(int x0, int y0, int x1, int y1,
                                    int x2, int y2, int x3, int y3);
    quad_t q;
    q[0] = coord_t'(x0); q[1] = coord_t'(y0);
    q[2] = coord_t'(x1); q[3] = coord_t'(y1);
    q[4] = coord_t'(x2); q[5] = coord_t'(y2);
    q[6] = coord_t'(x3); q[7] = coord_t'(y3);
    return q;
  endfunction

  // Rectangle centered at (cx, cy) with half edge u and half edge t * perp(u)
  function automatic quad_t build_rect(int cx, int cy, int ux, int uy, int t);
    int vx, vy;
    vx = -uy * t;
    vy = ux * t;
    return corners(cx - ux - vx, cy - uy - vy, cx + ux - vx, cy + uy - vy,
                   cx + ux + vx, cy + uy + vy, cx - ux + vx, cy - uy + vy);
  endfunction

  function automatic quad_t noise_rect();
    quad_t q;
    for (int i = 0; i < 2*ros_pkg::NUM_CORNERS; i++) q[i] = coord_t'($urandom);
    return q;
  endfunction

  // Send one beat after an optional idle gap; return once it is taken
  task automatic send_rect(logic cmd, quad_t q);
    int gap;
    gap = (tx_free || $urandom_range(0, 1) == 0) ? 0 : idle_len();
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= q;
    s_tuser  <= cmd;
    do @(posedge clk); while (!s_tready);
  endtask

  // Remember a shaped reference so later tests can be placed against it
  task automatic load_shaped(int cx, int cy, int ux, int uy, int t);
    ref_cx = cx; ref_cy = cy; ref_ux = ux; ref_uy = uy; ref_t = t;
    ref_shaped = 1'b1;
    send_rect(ros_pkg::CMD_LOAD, build_rect(cx, cy, ux, uy, t));
  endtask

  // Hold the sender until every pending result is out and loads have settled
  task automatic wait_drained();
    s_tvalid <= 1'b0;
    while (overlap_q.size() != 0) @(posedge clk);
    repeat (LATENCY + 2) @(posedge clk);
  endtask

  // ---------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------

  // Reference after reset is four corners at the origin
  task automatic test_before_load();
    send_rect(ros_pkg::CMD_TEST, build_rect(0, 0, 256, 0, 1));
    send_rect(ros_pkg::CMD_TEST, build_rect(2000, 2000, 256, 0, 1));
  endtask

  // Unit square [0,1]^2 in Q8.8: identical, touching, one LSB apart, inside
  task automatic test_axis_aligned();
    load_shaped(128, 128, 128, 0, 1);
    send_rect(ros_pkg::CMD_TEST, build_rect(128, 128, 128, 0, 1));
    send_rect(ros_pkg::CMD_TEST, build_rect(384, 128, 128, 0, 1));
    send_rect(ros_pkg::CMD_TEST, build_rect(385, 128, 128, 0, 1));
    send_rect(ros_pkg::CMD_TEST, build_rect(128, -128, 128, 0, 1));
    send_rect(ros_pkg::CMD_TEST, build_rect(128, 128, 10, 0, 1));
  endtask

  // Rotated rectangles, zero-length edges, and a point as reference
  task automatic test_rotated_degenerate();
    // diamond past the corner: only its own diagonal axis separates
    send_rect(ros_pkg::CMD_TEST, build_rect(400, 400, 100, 100, 1));
    send_rect(ros_pkg::CMD_TEST, build_rect(300, 300, 100, 100, 1));
    send_rect(ros_pkg::CMD_TEST, build_rect(50, 50, 0, 0, 1));
    send_rect(ros_pkg::CMD_TEST, build_rect(300, 50, 0, 0, 1));
    send_rect(ros_pkg::CMD_TEST, build_rect(128, -100, 0, 200, 0));
    load_shaped(1000, 1000, 0, 0, 1);
    send_rect(ros_pkg::CMD_TEST, build_rect(1000, 1000, 50, 20, 2));
    send_rect(ros_pkg::CMD_TEST, build_rect(1200, 1000, 50, 20, 2));
  endtask

  // Full-scale coordinates and corner orders that are not rectangles
  task automatic test_extremes();
    load_shaped(0, 0, 0, 0, 0);
    ref_shaped = 1'b0;
    send_rect(ros_pkg::CMD_LOAD,
              corners(-32768, -32768, 32767, -32768, 32767, 32767, -32768, 32767));
    send_rect(ros_pkg::CMD_TEST,
              corners(-32768, -32768, 32767, -32768, 32767, 32767, -32768, 32767));
    send_rect(ros_pkg::CMD_TEST, build_rect(0, 0, 16, 16, 1));
    send_rect(ros_pkg::CMD_TEST,
              corners(32767, 32767, 32767, 32767, 32767, 32767, 32767, 32767));
    send_rect(ros_pkg::CMD_TEST,
              corners(32767, -32768, -32768, 32767, -32768, -32768, 32767, 32767));
    send_rect(ros_pkg::CMD_LOAD,
              corners(32767, 32767, -32768, 32767, -32768, -32768, 32767, -32768));
    send_rect(ros_pkg::CMD_TEST, corners(-32768, 32767, 32767, -32768, 0, 0, -1, -1));
  endtask

  // Pick one test rectangle against the current reference
  function automatic quad_t pick_test();
    int sel, s, ox, oy, vx, vy;
    sel = $urandom_range(0, 99);
    if (!ref_shaped && sel < 75) sel = 80;
    vx = -ref_uy * ref_t;
    vy = ref_ux * ref_t;
    s  = ($urandom_range(0, 1) == 0) ? 2 : -2;
    if (sel < 40) begin
      ox = int'($urandom_range(0, 8000)) - 4000;
      oy = int'($urandom_range(0, 8000)) - 4000;
      return build_rect(ref_cx + ox, ref_cy + oy, int'($urandom_range(0, 3000)) - 1500,
                        int'($urandom_range(0, 3000)) - 1500, $urandom_range(1, 3));
    end else if (sel < 48) begin
      // same shape shifted by a whole edge: ranges just touch
      return build_rect(ref_cx + s * ref_ux, ref_cy + s * ref_uy, ref_ux, ref_uy, ref_t);
    end else if (sel < 56) begin
      return build_rect(ref_cx + s * vx, ref_cy + s * vy, ref_ux, ref_uy, ref_t);
    end else if (sel < 65) begin
      // shifted a little past touching
      ox = int'($urandom_range(0, 6)) - 3;
      oy = int'($urandom_range(0, 6)) - 3;
      return build_rect(ref_cx + s * ref_ux + ox, ref_cy + s * ref_uy + oy,
                        ref_ux, ref_uy, ref_t);
    end else if (sel < 75) begin
      // point, segment or square
      ox = int'($urandom_range(0, 6000)) - 3000;
      oy = int'($urandom_range(0, 6000)) - 3000;
      return build_rect(ref_cx + ox, ref_cy + oy, int'($urandom_range(0, 2)) * 300,
                        int'($urandom_range(0, 2)) * 300, $urandom_range(0, 1));
    end else if (sel < 90) begin
      return noise_rect();
    end
    return build_rect(int'($urandom_range(0, 4000)) - 2000, int'($urandom_range(0, 4000)) - 2000,
                      int'($urandom_range(0, 12000)) - 6000, int'($urandom_range(0, 4000)) - 2000,
                      1);
  endfunction

  // Pause the sender with tests in flight, then load right behind tests
  task automatic test_pause_drain();
    load_shaped(-500, 700, 400, -150, 2);
    repeat (6) send_rect(ros_pkg::CMD_TEST, pick_test());
    wait_drained();
    repeat (3) send_rect(ros_pkg::CMD_TEST, pick_test());
    load_shaped(300, -300, 200, 200, 1);
    repeat (3) send_rect(ros_pkg::CMD_TEST, pick_test());
    wait_drained();
  endtask

  // Mostly one reference followed by tests against it, some noise loads
  task automatic test_random_stream(int n_items);
    int sent, n_tests;
    sent = 0;
    while (sent < n_items) begin
      tx_free = ($urandom_range(0, 5) == 0);
      rx_free = ($urandom_range(0, 5) == 0);
      if ($urandom_range(0, 4) == 0) begin
        ref_shaped = 1'b0;
        send_rect(ros_pkg::CMD_LOAD, noise_rect());
      end else begin
        load_shaped(int'($urandom_range(0, 12000)) - 6000, int'($urandom_range(0, 12000)) - 6000,
                    int'($urandom_range(0, 3000)) - 1500, int'($urandom_range(0, 3000)) - 1500,
                    $urandom_range(1, 3));
      end
      n_tests = $urandom_range(1, 8);
      repeat (n_tests) send_rect(ros_pkg::CMD_TEST, pick_test());
      sent += n_tests + 1;
    end
    tx_free = 1'b0;
    rx_free = 1'b0;
  endtask

  // ---------------------------------------------------------------------
  // Sequence
  // ---------------------------------------------------------------------

  initial begin
    int waited;
    ref_shaped = 1'b0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    test_before_load();
    test_axis_aligned();
    test_rotated_degenerate();
    test_extremes();
    test_pause_drain();
    test_random_stream(RAND_ITEMS);

    // Drain outstanding results, then let the pipeline settle
    s_tvalid <= 1'b0;
    waited = 0;
    while (overlap_q.size() != 0 && waited < 100000) begin
      @(posedge clk);
      waited++;
    end
    repeat (LATENCY + 5) @(posedge clk);
    if (overlap_q.size() != 0)
      note_fail($sformatf("%0d expected results never arrived", overlap_q.size()));

    if (fail_count == 0) begin
      $display("** rect_overlap_sat: PASSED **");
    end else begin
      $display("** rect_overlap_sat: FAILED **");
    end
    $finish;
  end

endmodule
